// ===== rtl/core/q4k_q8k_row_dot_product_core_macros.svh =====
// ----------------------------------------------------------------------------
// q4k/q8k row dot product core assertion macros
// shared assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef Q4K_Q8K_ROW_DOT_PRODUCT_CORE_MACROS_SVH
`define Q4K_Q8K_ROW_DOT_PRODUCT_CORE_MACROS_SVH
`ifndef SYNTH
// same-cycle implication
`define QK_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");
// next-cycle implication
`define QK_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");
`else
`define QK_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define QK_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/qkdp_pkg.sv =====
// ----------------------------------------------------------------------------
// qkdp_pkg
// types and constants shared by the row dot product core
// ----------------------------------------------------------------------------
package qkdp_pkg;

	localparam int SUPERBLOCK_ELEMS = 256;
	localparam int BEATS = SUPERBLOCK_ELEMS / 16;
	localparam int BEAT_W = $clog2(BEATS);
	localparam int FOLD_STEPS = 10;
	localparam int STEP_W = $clog2(FOLD_STEPS);

	localparam logic CMD_HEADER = 1'b0;
	localparam logic CMD_DATA = 1'b1;

	localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
	localparam logic [31:0] FP32_POS_ZERO = 32'h0000_0000;

	typedef enum logic [2:0] {
		OP_H2F_W,
		OP_H2F_M,
		OP_MUL_DA,
		OP_MUL_T,
		OP_CVT_ISUM,
		OP_CVT_MSUM,
		OP_ADD_R,
		OP_SUB_R
	} fold_op_t;

	typedef enum logic [1:0] {
		FPU_MUL,
		FPU_ADD,
		FPU_CVT_INT,
		FPU_CVT_HALF
	} fpu_op_t;

	typedef struct packed {
		logic     load_hdr;
		logic     load_data;
		logic     dot;
		logic     acc;
		logic     fold_start;
		fold_op_t fold_op;
		logic     clear_sums;
		logic     emit;
	} qkdp_cmd_t;

	typedef struct packed {
		logic beat_end;
		logic fpu_done;
		logic out_free;
	} qkdp_stat_t;

	// fold order: r += (dw*da)*isum, then r -= (dmin*da)*msum
	function automatic fold_op_t fold_step_op(input logic [STEP_W-1:0] step);
		fold_op_t op;
		case (int'(step))
			0: op = OP_H2F_W;
			1: op = OP_MUL_DA;
			2: op = OP_CVT_ISUM;
			3: op = OP_MUL_T;
			4: op = OP_ADD_R;
			5: op = OP_H2F_M;
			6: op = OP_MUL_DA;
			7: op = OP_CVT_MSUM;
			8: op = OP_MUL_T;
			default: op = OP_SUB_R;
		endcase
		return op;
	endfunction

endpackage

// ===== rtl/core/q4k_q8k_row_dot_product_core.sv =====
// ----------------------------------------------------------------------------
// q4k_q8k_row_dot_product_core
// dot product of one 4-bit weight row with one 8-bit activation vector
//   input stream: a header beat (tuser 0) opens each 256-element superblock
//   with the fp16 weight scale and min, fp32 activation scale and 12 packed
//   scale bytes; 16 data beats (tuser 1) follow, each 8 weight bytes and 16
//   int8 activations; tlast on a data beat closes the row
//   output stream: one fp32 row sum per row, a nan always as 0x7fc00000
//   header beat: loaded as it is accepted; data beat: accept, dot, acc states
//   the 16th beat adds a fold of 10 fp32 operations through one shared
//   multi-cycle fpu, each lasting as long as its normalize shifts need
//   m_tvalid rises from the registered slot after the emit state that follows the acc (or last fold step) of tlast
//   one output slot: a held result does not block new beats; only the next
//   result waits for the slot, so a stalled receiver stalls the input then
//   reset clears scales, mins, beat counter, integer sums and row sum (+0)
// ----------------------------------------------------------------------------
`include "q4k_q8k_row_dot_product_core_macros.svh"

module q4k_q8k_row_dot_product_core import qkdp_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// weight_scale_bits[15:0], weight_min_bits[31:16], act_scale_bits[63:32],
	// scale_bytes_low[127:64], scale_bytes_high[159:128], weight_bytes[223:160],
	// act_low_group[287:224], act_high_group[351:288]
	input  logic [351:0] s_tdata,
	// command[0]
	input  logic [0:0]   s_tuser,
	// last_of_row
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// dot_value[31:0]
	output logic [31:0]  m_tdata
);

	qkdp_cmd_t  cmd;
	qkdp_stat_t stat;

	// sequencer: owns the input handshake and every datapath step
	qkdp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_command (s_tuser[0]),
		.in_last    (s_tlast),
		.in_ready   (s_tready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath: header is captured straight from the bus on the accept edge,
	// data beats are registered and then reduced in the dot and acc steps
	qkdp_datapath u_datapath (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.stat              (stat),
		.weight_scale_bits (s_tdata[15:0]),
		.weight_min_bits   (s_tdata[31:16]),
		.act_scale_bits    (s_tdata[63:32]),
		.scale_bytes_low   (s_tdata[127:64]),
		.scale_bytes_high  (s_tdata[159:128]),
		.weight_bytes      (s_tdata[223:160]),
		.act_low_group     (s_tdata[287:224]),
		.act_high_group    (s_tdata[351:288]),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.out_data          (m_tdata)
	);

	// a result is only written into a free or draining slot
	`QK_ASSERT_IMP(a_emit_slot_free, clk, arst_n, cmd.emit, stat.out_free)
	// a data beat keeps the input closed while it is reduced
	`QK_ASSERT_NEXT(a_data_beat_busy, clk, arst_n, s_tvalid && s_tready && (s_tuser[0] == CMD_DATA), !s_tready)
	// the fpu only finishes work while a fold holds the input
	`QK_ASSERT_IMP(a_fpu_in_fold, clk, arst_n, stat.fpu_done, !s_tready)

endmodule

// ===== rtl/core/qkdp_fpu.sv =====
// ----------------------------------------------------------------------------
// qkdp_fpu
// multi-cycle fp32 unit: mul, add, int32 and fp16 conversion, round to even
// ----------------------------------------------------------------------------
module qkdp_fpu import qkdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  fpu_op_t     op,
	input  logic [31:0] a,
	input  logic [31:0] b,
	input  logic        negate_b,
	input  logic [31:0] int_val,
	input  logic [15:0] half_val,
	output logic [31:0] result,
	output logic        done
);

	localparam int MW = 52;
	localparam int EW = 12;
	localparam int FRAC_BIAS = 150;
	localparam int FRAME_SHIFT = 26;
	localparam int FRAME_W = 24 + FRAME_SHIFT;
	localparam int HALF_OFS = 25;
	localparam int HALF_SUB_OFS = 24;
	localparam int EXP_TOP = MW - 1 + 127;
	localparam int EXP_MAX = 255;

	typedef enum logic [1:0] {FS_IDLE, FS_NORM, FS_ROUND, FS_DONE} fpu_state_t;

	fpu_state_t state_q;

	logic [MW-1:0]        mant_q;
	logic signed [EW-1:0] exp_q;
	logic                 sign_q;
	logic                 spec_q;
	logic [31:0]          spec_bits_q;
	logic [31:0]          result_q;

	// operand unpack
	logic        a_sign, b_sign;
	logic [7:0]  a_exp, b_exp, a_eu, b_eu;
	logic [22:0] a_frac, b_frac;
	logic [23:0] a_man, b_man;
	logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

	// prepared value
	logic [MW-1:0]        p_mant;
	logic signed [EW-1:0] p_exp;
	logic                 p_sign;
	logic                 p_spec;
	logic [31:0]          p_spec_bits;

	// add alignment
	logic                 big_is_a;
	logic [7:0]           l_eu, s_eu, d;
	logic [23:0]          l_man, s_man;
	logic                 l_sign, s_sign;
	logic [FRAME_W-1:0]   big_f, small_f, sh_small, aligned;
	logic                 add_lost;
	logic [FRAME_W:0]     sum_f;
	logic [47:0]          prod;
	logic [31:0]          int_mag;
	logic [4:0]           h_exp;
	logic [9:0]           h_frac;

	// rounding
	logic signed [EW-1:0] be, eb;
	logic                 be_pos;
	logic [EW-1:0]        sh;
	logic [MW-1:0]        t_mant;
	logic                 r_lost, g_bit, s_bit, inc;
	logic [23:0]          m24;
	logic [24:0]          r25;
	logic [31:0]          round_bits;

	assign a_sign = a[31];
	assign a_exp = a[30:23];
	assign a_frac = a[22:0];
	assign a_man = {|a_exp, a_frac};
	assign a_eu = (a_exp == 8'd0) ? 8'd1 : a_exp;
	assign a_nan = (&a_exp) && (|a_frac);
	assign a_inf = (&a_exp) && !(|a_frac);
	assign a_zero = !(|a_exp) && !(|a_frac);

	assign b_sign = b[31] ^ negate_b;
	assign b_exp = b[30:23];
	assign b_frac = b[22:0];
	assign b_man = {|b_exp, b_frac};
	assign b_eu = (b_exp == 8'd0) ? 8'd1 : b_exp;
	assign b_nan = (&b_exp) && (|b_frac);
	assign b_inf = (&b_exp) && !(|b_frac);
	assign b_zero = !(|b_exp) && !(|b_frac);

	assign prod = a_man * b_man;
	assign int_mag = int_val[31] ? (~int_val + 32'd1) : int_val;
	assign h_exp = half_val[14:10];
	assign h_frac = half_val[9:0];

	// larger magnitude first, smaller shifted right with sticky
	always_comb begin
		big_is_a = {a_eu, a_man} >= {b_eu, b_man};
		l_eu = big_is_a ? a_eu : b_eu;
		l_man = big_is_a ? a_man : b_man;
		l_sign = big_is_a ? a_sign : b_sign;
		s_eu = big_is_a ? b_eu : a_eu;
		s_man = big_is_a ? b_man : a_man;
		s_sign = big_is_a ? b_sign : a_sign;
		d = l_eu - s_eu;
		big_f = {l_man, {FRAME_SHIFT{1'b0}}};
		small_f = {s_man, {FRAME_SHIFT{1'b0}}};
		if (d >= 8'(FRAME_W)) begin
			sh_small = '0;
			add_lost = |s_man;
		end else begin
			sh_small = small_f >> d;
			add_lost = |(small_f & ~({FRAME_W{1'b1}} << d));
		end
		aligned = {sh_small[FRAME_W-1:1], sh_small[0] | add_lost};
		if (l_sign == s_sign) begin
			sum_f = {1'b0, big_f} + {1'b0, aligned};
		end else begin
			sum_f = {1'b0, big_f} - {1'b0, aligned};
		end
	end

	always_comb begin
		p_mant = '0;
		p_exp = '0;
		p_sign = 1'b0;
		p_spec = 1'b0;
		p_spec_bits = FP32_QNAN;
		case (op)
			FPU_MUL: begin
				p_sign = a_sign ^ b_sign;
				if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
					p_spec = 1'b1;
				end else if (a_inf || b_inf) begin
					p_spec = 1'b1;
					p_spec_bits = {a_sign ^ b_sign, 8'hFF, 23'd0};
				end
				p_mant = MW'(prod);
				p_exp = EW'(a_eu) + EW'(b_eu) - EW'(2 * FRAC_BIAS);
			end
			FPU_ADD: begin
				if (a_nan || b_nan || (a_inf && b_inf && (a_sign != b_sign))) begin
					p_spec = 1'b1;
				end else if (a_inf) begin
					p_spec = 1'b1;
					p_spec_bits = {a_sign, 8'hFF, 23'd0};
				end else if (b_inf) begin
					p_spec = 1'b1;
					p_spec_bits = {b_sign, 8'hFF, 23'd0};
				end
				p_mant = MW'(sum_f);
				p_exp = EW'(l_eu) - EW'(FRAC_BIAS + FRAME_SHIFT);
				// exact cancellation gives +0 unless both are negative
				p_sign = (sum_f == '0) ? (a_sign & b_sign) : l_sign;
			end
			FPU_CVT_INT: begin
				p_mant = MW'(int_mag);
				p_exp = '0;
				p_sign = int_val[31];
			end
			FPU_CVT_HALF: begin
				p_sign = half_val[15];
				if (&h_exp) begin
					p_spec = 1'b1;
					if (h_frac == 10'd0) begin
						p_spec_bits = {half_val[15], 8'hFF, 23'd0};
					end
				end else if (h_exp == 5'd0) begin
					p_mant = MW'(h_frac);
					p_exp = '0 - EW'(HALF_SUB_OFS);
				end else begin
					p_mant = MW'({1'b1, h_frac});
					p_exp = EW'(h_exp) - EW'(HALF_OFS);
				end
			end
			default: ;
		endcase
	end

	// pack the normalized value, denormalizing below the normal range
	always_comb begin
		be = exp_q + EW'(EXP_TOP);
		be_pos = !be[EW-1] && (be != '0);
		sh = be_pos ? '0 : (EW'(1) - be);
		if (sh >= EW'(MW)) begin
			t_mant = '0;
			r_lost = |mant_q;
		end else begin
			t_mant = mant_q >> sh;
			r_lost = |(mant_q & ~({MW{1'b1}} << sh));
		end
		m24 = t_mant[MW-1 -: 24];
		g_bit = t_mant[MW-25];
		s_bit = (|t_mant[MW-26:0]) | r_lost;
		inc = g_bit & (s_bit | m24[0]);
		r25 = {1'b0, m24} + {24'd0, inc};
		eb = be + EW'(r25[24]);
		if (be_pos) begin
			if (eb >= EW'(EXP_MAX)) begin
				round_bits = {sign_q, 8'hFF, 23'd0};
			end else begin
				round_bits = {sign_q, eb[7:0], r25[22:0]};
			end
		end else begin
			round_bits = {sign_q, 7'd0, r25[23], r25[22:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			case (state_q)
				FS_IDLE: begin
					if (start) state_q <= FS_NORM;
				end
				FS_NORM: begin
					if (spec_q || (mant_q == '0)) begin
						state_q <= FS_DONE;
					end else if (mant_q[MW-1]) begin
						state_q <= FS_ROUND;
					end
				end
				FS_ROUND: state_q <= FS_DONE;
				FS_DONE: state_q <= FS_IDLE;
				default: state_q <= FS_IDLE;
			endcase
		end
	end

	// datapath registers, no reset
	always_ff @(posedge clk) begin
		case (state_q)
			FS_IDLE: begin
				if (start) begin
					mant_q <= p_mant;
					exp_q <= p_exp;
					sign_q <= p_sign;
					spec_q <= p_spec;
					spec_bits_q <= p_spec_bits;
				end
			end
			FS_NORM: begin
				if (spec_q) begin
					result_q <= spec_bits_q;
				end else if (mant_q == '0) begin
					result_q <= {sign_q, 31'd0};
				end else if (!mant_q[MW-1]) begin
					if (mant_q[MW-1 -: 8] == 8'd0) begin
						mant_q <= mant_q << 8;
						exp_q <= exp_q - EW'(8);
					end else begin
						mant_q <= mant_q << 1;
						exp_q <= exp_q - EW'(1);
					end
				end
			end
			FS_ROUND: result_q <= round_bits;
			default: ;
		endcase
	end

	assign result = result_q;
	assign done = (state_q == FS_DONE);

endmodule

// ===== rtl/core/qkdp_datapath.sv =====
// ----------------------------------------------------------------------------
// qkdp_datapath
// scale decode, integer beat sums, fp fold registers and output slot
// ----------------------------------------------------------------------------
module qkdp_datapath import qkdp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  qkdp_cmd_t   cmd,
	output qkdp_stat_t  stat,
	input  logic [15:0] weight_scale_bits,
	input  logic [15:0] weight_min_bits,
	input  logic [31:0] act_scale_bits,
	input  logic [63:0] scale_bytes_low,
	input  logic [31:0] scale_bytes_high,
	input  logic [63:0] weight_bytes,
	input  logic [63:0] act_low_group,
	input  logic [63:0] act_high_group,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] out_data
);

	logic [5:0]  sub_scales_q [8];
	logic [5:0]  sub_mins_q [8];
	logic [15:0] weight_scale_q;
	logic [15:0] weight_min_q;
	logic [31:0] act_scale_q;
	logic [BEAT_W-1:0] beat_q;
	logic signed [31:0] isum_q;
	logic signed [31:0] msum_q;
	logic [31:0] rsum_q;
	logic [31:0] t1_q, t2_q;
	logic [31:0] out_q;
	logic        out_valid_q;
	fold_op_t    fold_op_q;

	logic [63:0] wbytes_q, alo_q, ahi_q;

	logic signed [15:0] dot_lo_s1, dot_hi_s1;
	logic signed [10:0] sum_lo_s1, sum_hi_s1;

	logic [7:0] q_byte [12];
	logic [5:0] dec_scale [8];
	logic [5:0] dec_min [8];

	logic signed [15:0] dot_lo, dot_hi;
	logic signed [10:0] sum_lo, sum_hi;
	logic signed [7:0]  al, ah;
	logic signed [4:0]  wl, wh;

	logic [2:0] lo_sub, hi_sub;
	logic signed [22:0] sp_lo, sp_hi;
	logic signed [17:0] mp_lo, mp_hi;
	logic signed [31:0] isum_next, msum_next;

	fpu_op_t     fpu_op;
	logic [31:0] fpu_a, fpu_b, fpu_int, fpu_result;
	logic [15:0] fpu_half;
	logic        fpu_neg, fpu_done;
	logic        rsum_nan;

	// header scale decode
	always_comb begin
		for (int j = 0; j < 8; j++) q_byte[j] = scale_bytes_low[8*j +: 8];
		for (int j = 0; j < 4; j++) q_byte[8+j] = scale_bytes_high[8*j +: 8];
		for (int j = 0; j < 4; j++) begin
			dec_scale[j] = q_byte[j][5:0];
			dec_min[j] = q_byte[j+4][5:0];
		end
		for (int j = 4; j < 8; j++) begin
			dec_scale[j] = {q_byte[j-4][7:6], q_byte[j+4][3:0]};
			dec_min[j] = {q_byte[j][7:6], q_byte[j+4][7:4]};
		end
	end

	// nibble by activation dot products and activation sums of one beat
	always_comb begin
		dot_lo = '0;
		dot_hi = '0;
		sum_lo = '0;
		sum_hi = '0;
		al = '0;
		ah = '0;
		wl = '0;
		wh = '0;
		for (int i = 0; i < 8; i++) begin
			al = signed'(alo_q[8*i +: 8]);
			ah = signed'(ahi_q[8*i +: 8]);
			wl = signed'({1'b0, wbytes_q[8*i +: 4]});
			wh = signed'({1'b0, wbytes_q[8*i+4 +: 4]});
			dot_lo = dot_lo + 16'(wl * al);
			dot_hi = dot_hi + 16'(wh * ah);
			sum_lo = sum_lo + 11'(al);
			sum_hi = sum_hi + 11'(ah);
		end
	end

	assign lo_sub = {beat_q[BEAT_W-1 -: 2], 1'b0};
	assign hi_sub = {beat_q[BEAT_W-1 -: 2], 1'b1};
	assign sp_lo = signed'({1'b0, sub_scales_q[lo_sub]}) * dot_lo_s1;
	assign sp_hi = signed'({1'b0, sub_scales_q[hi_sub]}) * dot_hi_s1;
	assign mp_lo = signed'({1'b0, sub_mins_q[lo_sub]}) * sum_lo_s1;
	assign mp_hi = signed'({1'b0, sub_mins_q[hi_sub]}) * sum_hi_s1;
	assign isum_next = isum_q + 32'(sp_lo) + 32'(sp_hi);
	assign msum_next = msum_q + 32'(mp_lo) + 32'(mp_hi);

	// fpu operand select for the step being issued
	always_comb begin
		fpu_op = FPU_MUL;
		fpu_a = t1_q;
		fpu_b = act_scale_q;
		fpu_neg = 1'b0;
		fpu_int = isum_q;
		fpu_half = weight_scale_q;
		case (cmd.fold_op)
			OP_H2F_W: fpu_op = FPU_CVT_HALF;
			OP_H2F_M: begin
				fpu_op = FPU_CVT_HALF;
				fpu_half = weight_min_q;
			end
			OP_MUL_DA: fpu_op = FPU_MUL;
			OP_MUL_T: fpu_b = t2_q;
			OP_CVT_ISUM: fpu_op = FPU_CVT_INT;
			OP_CVT_MSUM: begin
				fpu_op = FPU_CVT_INT;
				fpu_int = msum_q;
			end
			OP_ADD_R: begin
				fpu_op = FPU_ADD;
				fpu_a = rsum_q;
				fpu_b = t1_q;
			end
			OP_SUB_R: begin
				fpu_op = FPU_ADD;
				fpu_a = rsum_q;
				fpu_b = t1_q;
				fpu_neg = 1'b1;
			end
			default: ;
		endcase
	end

	qkdp_fpu u_fpu (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.fold_start),
		.op       (fpu_op),
		.a        (fpu_a),
		.b        (fpu_b),
		.negate_b (fpu_neg),
		.int_val  (fpu_int),
		.half_val (fpu_half),
		.result   (fpu_result),
		.done     (fpu_done)
	);

	assign rsum_nan = (&rsum_q[30:23]) && (|rsum_q[22:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < 8; j++) begin
				sub_scales_q[j] <= '0;
				sub_mins_q[j] <= '0;
			end
			weight_scale_q <= '0;
			weight_min_q <= '0;
			act_scale_q <= '0;
			beat_q <= '0;
			isum_q <= '0;
			msum_q <= '0;
			rsum_q <= FP32_POS_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load_hdr) begin
				for (int j = 0; j < 8; j++) begin
					sub_scales_q[j] <= dec_scale[j];
					sub_mins_q[j] <= dec_min[j];
				end
				weight_scale_q <= weight_scale_bits;
				weight_min_q <= weight_min_bits;
				act_scale_q <= act_scale_bits;
				beat_q <= '0;
				isum_q <= '0;
				msum_q <= '0;
			end
			if (cmd.acc) begin
				isum_q <= isum_next;
				msum_q <= msum_next;
				beat_q <= stat.beat_end ? '0 : beat_q + BEAT_W'(1);
			end
			if (cmd.clear_sums) begin
				isum_q <= '0;
				msum_q <= '0;
			end
			if (fpu_done && ((fold_op_q == OP_ADD_R) || (fold_op_q == OP_SUB_R))) begin
				rsum_q <= fpu_result;
			end
			if (cmd.emit) begin
				rsum_q <= FP32_POS_ZERO;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_data) begin
			wbytes_q <= weight_bytes;
			alo_q <= act_low_group;
			ahi_q <= act_high_group;
		end
		if (cmd.dot) begin
			dot_lo_s1 <= dot_lo;
			dot_hi_s1 <= dot_hi;
			sum_lo_s1 <= sum_lo;
			sum_hi_s1 <= sum_hi;
		end
		if (cmd.fold_start) fold_op_q <= cmd.fold_op;
		if (fpu_done) begin
			case (fold_op_q)
				OP_CVT_ISUM, OP_CVT_MSUM: t2_q <= fpu_result;
				OP_ADD_R, OP_SUB_R: ;
				default: t1_q <= fpu_result;
			endcase
		end
		if (cmd.emit) out_q <= rsum_nan ? FP32_QNAN : rsum_q;
	end

	assign stat.beat_end = (beat_q == BEAT_W'(BEATS - 1));
	assign stat.fpu_done = fpu_done;
	assign stat.out_free = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

endmodule

// ===== rtl/core/qkdp_ctrl.sv =====
// ----------------------------------------------------------------------------
// qkdp_ctrl
// sequencer for header loads, data beats, the superblock fold and the emit
// ----------------------------------------------------------------------------
module qkdp_ctrl import qkdp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_command,
	input  logic       in_last,
	output logic       in_ready,
	input  qkdp_stat_t stat,
	output qkdp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DOT,
		ST_ACC,
		ST_FSTART,
		ST_FWAIT,
		ST_EMIT
	} ctrl_state_t;

	ctrl_state_t       state_q;
	logic [STEP_W-1:0] step_q;
	logic              last_q;
	logic              last_step;

	assign last_step = (step_q == STEP_W'(FOLD_STEPS - 1));
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		cmd = '0;
		cmd.fold_op = fold_step_op(step_q);
		cmd.load_hdr = (state_q == ST_IDLE) && in_valid && (in_command == CMD_HEADER);
		cmd.load_data = (state_q == ST_IDLE) && in_valid && (in_command == CMD_DATA);
		cmd.dot = (state_q == ST_DOT);
		cmd.acc = (state_q == ST_ACC);
		cmd.fold_start = (state_q == ST_FSTART);
		cmd.clear_sums = (state_q == ST_FWAIT) && stat.fpu_done && last_step;
		cmd.emit = (state_q == ST_EMIT) && stat.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			last_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid && (in_command == CMD_DATA)) begin
						last_q <= in_last;
						state_q <= ST_DOT;
					end
				end
				ST_DOT: state_q <= ST_ACC;
				ST_ACC: begin
					if (stat.beat_end) begin
						step_q <= '0;
						state_q <= ST_FSTART;
					end else if (last_q) begin
						state_q <= ST_EMIT;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_FSTART: state_q <= ST_FWAIT;
				ST_FWAIT: begin
					if (stat.fpu_done) begin
						if (last_step) begin
							state_q <= last_q ? ST_EMIT : ST_IDLE;
						end else begin
							step_q <= step_q + STEP_W'(1);
							state_q <= ST_FSTART;
						end
					end
				end
				ST_EMIT: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
